@@ design/spr_pkg.sv @@
// ----------------------------------------------------------------------------
// spr_pkg - shared definitions for the stream pattern replace block
// Sizing constants, register index codes and the byte type used by the
// block and by its port checker.
// ----------------------------------------------------------------------------
package spr_pkg;

   localparam int MAX_PATTERN = 8;
   localparam int MAX_REPLACE = 8;

   localparam int LEN_W      = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;

   typedef logic [7:0] byte_type;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LEN   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_BYTES = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLACE_LEN   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLACE_BYTES = 2'd3;

endpackage

@@ design/stream_pattern_replace.sv @@
// ----------------------------------------------------------------------------
// stream_pattern_replace - streaming find and replace on a byte stream
// Holds a sliding window as long as the pattern, swaps matches for the
// replacement text and flushes the window at the end of each stream.
// ----------------------------------------------------------------------------
// Usage: each request word carries one stream byte and a flag marking the last
// byte of a stream. The block takes one request word per cycle as long as the
// response side keeps up: every accepted byte is folded into the window in the
// cycle it arrives, and the response words it causes (none, one, up to the
// pattern length on a final flush, or the whole replacement on a match) are
// loaded into a burst register that is drained one word per cycle while
// rsp_stall is low. An item therefore holds the response channel until all its
// words, at most max(MaxPattern, MaxReplace), have left; the next request word
// is taken in the same cycle as the last word of the previous burst leaves, so
// items that produce nothing or one word each run at one byte per cycle. A final
// byte that produces no data gives a single end marker word with byte_valid
// low. Write configuration only while the block is idle; writing the pattern
// length empties the window.
// ----------------------------------------------------------------------------
module stream_pattern_replace #(
   parameter int MaxPattern = spr_pkg::MAX_PATTERN,
   parameter int MaxReplace = spr_pkg::MAX_REPLACE
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  spr_pkg::byte_type             req_data_byte,
   input  logic                          req_final_byte,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output spr_pkg::byte_type             rsp_out_byte,
   output logic                          rsp_byte_valid,
   output logic                          rsp_run_end,
   output logic                          rsp_stream_end,
   // configuration write port
   input  logic                          csr_wr_en,
   input  logic [spr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [spr_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import spr_pkg::*;

   localparam int BurstDepth = (MaxPattern > MaxReplace) ? MaxPattern : MaxReplace;
   localparam int CntW       = $clog2(MaxPattern + 1);
   localparam int BstW       = $clog2(BurstDepth + 1);
   localparam int WinW       = MaxPattern * 8;
   localparam int RepW       = MaxReplace * 8;
   localparam int BstDataW   = BurstDepth * 8;

   // configuration registers
   logic [LEN_W-1:0]    pat_len_ff;
   logic [WinW-1:0]     pat_bytes_ff;
   logic [LEN_W-1:0]    rep_len_ff;
   logic [RepW-1:0]     rep_bytes_ff;

   // window: oldest byte in the low bits
   logic [WinW-1:0]     win_ff;
   logic [WinW-1:0]     win_in;
   logic [CntW-1:0]     win_cnt_ff;
   logic [CntW-1:0]     win_cnt_in;

   // response burst: next word to send in the low byte
   logic [BstDataW-1:0] bst_ff;
   logic [BstDataW-1:0] bst_in;
   logic [BstW-1:0]     bst_left_ff;
   logic [BstW-1:0]     bst_left_in;
   logic                bst_fin_ff;
   logic                bst_mark_ff;
   logic                bst_mark_in;

   logic                req_take;
   logic                rsp_take;

   logic [CntW-1:0]     plen;
   logic [BstW-1:0]     rlen;
   logic [CntW-1:0]     cnt_next;
   logic [WinW-1:0]     win_add;
   logic                win_full;
   logic                win_match;

   // ------------------------------------------------------------------------
   // Handshake. Take a new byte when the burst is empty or its last word is
   // leaving this cycle.
   // ------------------------------------------------------------------------
   assign rsp_valid = (bst_left_ff != '0);
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign req_stall = (bst_left_ff > BstW'(1)) || ((bst_left_ff == BstW'(1)) && rsp_stall);
   assign req_take  = req_valid && !req_stall;

   assign rsp_out_byte   = bst_ff[7:0];
   assign rsp_byte_valid = !bst_mark_ff;
   assign rsp_run_end    = (bst_left_ff == BstW'(1));
   assign rsp_stream_end = rsp_run_end && bst_fin_ff;

   // ------------------------------------------------------------------------
   // Effective lengths: anything beyond the maximum acts as the maximum.
   // ------------------------------------------------------------------------
   always_comb begin
      if (pat_len_ff > LEN_W'(MaxPattern)) begin
         plen = CntW'(MaxPattern);
      end else begin
         plen = pat_len_ff[CntW-1:0];
      end
      if (rep_len_ff > LEN_W'(MaxReplace)) begin
         rlen = BstW'(MaxReplace);
      end else begin
         rlen = rep_len_ff[BstW-1:0];
      end
   end

   // ------------------------------------------------------------------------
   // Append the incoming byte behind the held bytes, then compare the whole
   // pattern length against the pattern bytes.
   // ------------------------------------------------------------------------
   assign cnt_next = win_cnt_ff + CntW'(1);
   assign win_full = (cnt_next == plen);

   always_comb begin
      win_add   = win_ff;
      win_match = 1'b1;
      for (int k = 0; k < MaxPattern; k++) begin
         if (CntW'(k) == win_cnt_ff) begin
            win_add[k*8 +: 8] = req_data_byte;
         end
      end
      for (int k = 0; k < MaxPattern; k++) begin
         if ((CntW'(k) < plen) && (win_add[k*8 +: 8] != pat_bytes_ff[k*8 +: 8])) begin
            win_match = 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Next window and the burst one byte causes.
   //   pass through  : send the byte itself
   //   match         : send the replacement, empty the window
   //   full, no match: send the oldest byte, drop it from the window; on a
   //                   final byte the whole window goes out in order
   //   not yet full  : keep the byte; on a final byte flush the window
   // A final byte that leaves nothing to send turns into an end marker.
   // ------------------------------------------------------------------------
   always_comb begin
      win_in      = win_add;
      win_cnt_in  = win_cnt_ff;
      bst_in      = BstDataW'(win_add);
      bst_left_in = '0;
      bst_mark_in = 1'b0;

      priority if (plen == '0) begin
         win_in      = win_ff;
         bst_in      = BstDataW'(req_data_byte);
         bst_left_in = BstW'(1);
      end else if (win_full && win_match) begin
         bst_in      = BstDataW'(rep_bytes_ff);
         bst_left_in = rlen;
         win_cnt_in  = '0;
      end else if (win_full) begin
         win_in      = win_add >> 8;
         win_cnt_in  = plen - CntW'(1);
         bst_left_in = req_final_byte ? BstW'(plen) : BstW'(1);
      end else begin
         win_cnt_in  = cnt_next;
         bst_left_in = req_final_byte ? BstW'(cnt_next) : '0;
      end

      if (req_final_byte) begin
         win_cnt_in = '0;
      end

      if (req_final_byte && (bst_left_in == '0)) begin
         bst_mark_in  = 1'b1;
         bst_left_in  = BstW'(1);
         bst_in[7:0]  = 8'h00;
      end
   end

   // ------------------------------------------------------------------------
   // Control registers: configuration, window fill and burst count.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_len_ff   <= '0;
         pat_bytes_ff <= '0;
         rep_len_ff   <= '0;
         rep_bytes_ff <= '0;
         win_cnt_ff   <= '0;
         bst_left_ff  <= '0;
      end else begin
         if (req_take) begin
            win_cnt_ff  <= win_cnt_in;
            bst_left_ff <= bst_left_in;
         end else if (rsp_take) begin
            bst_left_ff <= bst_left_ff - BstW'(1);
         end

         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_PATTERN_LEN: begin
                  pat_len_ff <= csr_wdata[LEN_W-1:0];
                  // drop whatever the window held
                  win_cnt_ff <= '0;
               end
               CSR_PATTERN_BYTES: begin
                  pat_bytes_ff <= csr_wdata[WinW-1:0];
               end
               CSR_REPLACE_LEN: begin
                  rep_len_ff <= csr_wdata[LEN_W-1:0];
               end
               CSR_REPLACE_BYTES: begin
                  rep_bytes_ff <= csr_wdata[RepW-1:0];
               end
            endcase
         end
      end
   end

   // ------------------------------------------------------------------------
   // Payload registers: window bytes and burst words, no reset.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_take) begin
         win_ff      <= win_in;
         bst_ff      <= bst_in;
         bst_fin_ff  <= req_final_byte;
         bst_mark_ff <= bst_mark_in;
      end else if (rsp_take) begin
         // advance to the next word of the burst
         bst_ff <= bst_ff >> 8;
      end
   end

endmodule

@@ design/spr_checker.sv @@
// ----------------------------------------------------------------------------
// spr_checker - port level checks for stream_pattern_replace
// Watches the request and response channels and flags framing slips.
// ----------------------------------------------------------------------------
module spr_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input spr_pkg::byte_type rsp_out_byte,
   input logic              rsp_byte_valid,
   input logic              rsp_run_end,
   input logic              rsp_stream_end
);
   import spr_pkg::*;

   // nothing pending on the response side: never hold the request side
   a_idle_no_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with no response word pending");

   // last word of a run leaving: the next byte may enter in the same cycle
   a_run_end_frees_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_run_end) |-> !req_stall)
      else $error("request stalled while the last word of a run leaves");

   // the stream end closes a run
   a_stream_end_closes_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stream_end) |-> rsp_run_end)
      else $error("stream end without run end");

   // an empty word only ever marks the end of a stream, with a zero byte
   a_marker_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_byte_valid) |-> (rsp_stream_end && (rsp_out_byte == 8'h00)))
      else $error("empty word that is not a clean end marker");

   // hold a stalled response word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_out_byte)))
      else $error("stalled response word dropped or changed");

endmodule

bind stream_pattern_replace spr_checker u_spr_checker (.*);
